// ----- design/dfvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfvs_pkg: shared types and constants for the dipole field voxel sum
// Request and result payloads, the stored source entry, the per-source term
// result and the request kind codes.
// ----------------------------------------------------------------------------
package dfvs_pkg;

    // request kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // saturation bounds
    localparam logic [63:0] I64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64MIN = 64'h8000_0000_0000_0000;
    localparam logic [47:0] POS47  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG47  = 48'h8000_0000_0000;

    // one request
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        radius;
    } req_t;

    // one result
    typedef struct packed {
        logic signed [47:0] field_value;
        logic               saturated;
        logic               table_full;
    } res_t;

    // one stored source
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        radius;
    } src_t;

    // per-source term handed from the term engine to the accumulator
    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [63:0] value;
    } term_res_t;

endpackage

// ----- design/dfvs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfvs_cell: one source slot of the rotating source chain
// Holds one source entry; loads it on append and takes its neighbor's entry
// when the chain rotates.
// ----------------------------------------------------------------------------
module dfvs_cell
    import dfvs_pkg::*;
(
    input  logic clk,
    input  logic load,
    input  logic shift,
    input  src_t load_src,
    input  src_t next_src,
    output src_t src
);

    src_t src_reg;
    src_t src_next;

    // append wins over rotation (never both at once)
    always_comb
    begin
        src_next = src_reg;
        if (load)
        begin
            src_next = load_src;
        end
        else if (shift)
        begin
            src_next = next_src;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
    end

    assign src = src_reg;

endmodule

// ----- design/dfvs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfvs_div: bit-serial unsigned divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle, restoring.
// Quotient holds after the done pulse until the next start.
// ----------------------------------------------------------------------------
module dfvs_div
    import dfvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // one restoring step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[63]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd63;
            rem_next  = 32'd0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[31:0] : trial[31:0];
            dvd_next = {dvd_reg[62:0], ge};
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- design/dfvs_term.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfvs_term: field term of one source at one voxel
// Sequencer over one squarer, a serial square root, the serial divider and
// one 32x32 multiplier: (2dz^2-dx^2-dy^2)/r^5, saturated, in Q31.32.
// ----------------------------------------------------------------------------
module dfvs_term
    import dfvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  src_t      src,
    input  req_t      qry,
    output term_res_t res
);

    typedef enum logic [12:0] {
        T_IDLE  = 13'b0000000000001,
        T_SQ    = 13'b0000000000010,
        T_SUM   = 13'b0000000000100,
        T_NORM  = 13'b0000000001000,
        T_RATIO = 13'b0000000010000,
        T_SQRT  = 13'b0000000100000,
        T_BLEN  = 13'b0000001000000,
        T_DIV1  = 13'b0000010000000,
        T_DIV2  = 13'b0000100000000,
        T_DIV3  = 13'b0001000000000,
        T_MUL0  = 13'b0010000000000,
        T_MUL1  = 13'b0100000000000,
        T_FIN   = 13'b1000000000000
    } tstate_t;

    tstate_t     state_reg, state_next;
    term_res_t   res_reg, res_next;
    logic        div_go_reg, div_go_next;
    logic [63:0] div_a_reg, div_a_next;
    logic [31:0] div_b_reg, div_b_next;

    logic [28:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [26:0] rad_reg, rad_next;
    logic [1:0]  sq_cnt_reg, sq_cnt_next;
    logic [57:0] sqx_reg, sqx_next, sqy_reg, sqy_next, sqz_reg, sqz_next;
    logic [57:0] radsq_reg, radsq_next;
    logic [57:0] r2s_reg, r2s_next;
    logic [58:0] nms_reg, nms_next;
    logic        neg_reg, neg_next;
    logic [31:0] ratio_reg, ratio_next;
    logic [57:0] sv_reg, sv_next, sr_reg, sr_next, sbit_reg, sbit_next;
    logic [28:0] rr_reg, rr_next, btmp_reg, btmp_next;
    logic [4:0]  b_reg, b_next;
    logic [63:0] inv3_reg, inv3_next;
    logic        inv_sat_reg, inv_sat_next;
    logic [63:0] p0_reg, p0_next, p1_reg, p1_next;

    logic        div_done;
    logic [63:0] div_q;

    logic [32:0] dx, dy, dz, mx, my, mz;
    logic [28:0] mop;
    logic [57:0] sq_prod;
    logic [57:0] r2_sum;
    logic [59:0] num, nmag;
    logic [58:0] s_try;
    logic        s_ge;
    logic [57:0] sr_step, sv_step;
    logic [4:0]  sh1;
    logic [63:0] dshift;
    logic [5:0]  s_dn, s_up;
    logic [63:0] inv_lim;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [95:0] prod;
    logic [65:0] shifted;
    logic        mul_sat;
    logic [63:0] tm;

    dfvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // datapath pieces
    always_comb
    begin
        // differences and magnitudes, 33 bits
        dx = {src.x[31], src.x} - {qry.pos_x[31], qry.pos_x};
        dy = {src.y[31], src.y} - {qry.pos_y[31], qry.pos_y};
        dz = {src.z[31], src.z} - {qry.pos_z[31], qry.pos_z};
        mx = dx[32] ? (~dx + 33'd1) : dx;
        my = dy[32] ? (~dy + 33'd1) : dy;
        mz = dz[32] ? (~dz + 33'd1) : dz;

        // shared squarer
        case (sq_cnt_reg)
            2'd0:    mop = ax_reg;
            2'd1:    mop = ay_reg;
            2'd2:    mop = az_reg;
            default: mop = {2'b00, rad_reg};
        endcase
        sq_prod = {29'd0, mop} * {29'd0, mop};

        // r^2 and numerator
        r2_sum = sqx_reg + sqy_reg + sqz_reg;
        num    = {1'b0, sqz_reg, 1'b0} - {2'b00, sqx_reg} - {2'b00, sqy_reg};
        nmag   = num[59] ? (~num + 60'd1) : num;

        // square root step
        s_try   = {1'b0, sr_reg} + {1'b0, sbit_reg};
        s_ge    = {1'b0, sv_reg} >= s_try;
        sr_step = s_ge ? ((sr_reg >> 1) + sbit_reg) : (sr_reg >> 1);
        sv_step = s_ge ? (sv_reg - s_try[57:0]) : sv_reg;

        // inverse cube scaling
        sh1     = b_reg - 5'd1;
        dshift  = div_q << sh1;
        s_dn    = {b_reg, 1'b0} - 6'd7;
        s_up    = 6'd7 - {b_reg, 1'b0};
        inv_lim = I64MAX >> s_up;

        // ratio times inverse cube, one half per cycle
        mul_b   = state_reg == T_MUL0 ? inv3_reg[31:0] : inv3_reg[63:32];
        mul_p   = {32'd0, ratio_reg} * {32'd0, mul_b};
        prod    = {32'd0, p0_reg} + {p1_reg, 32'd0};
        shifted = prod[95:30];
        mul_sat = |shifted[65:63];
        tm      = mul_sat ? I64MAX : {1'b0, shifted[62:0]};
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        res_next.done = 1'b0;
        div_go_next  = 1'b0;
        div_a_next   = div_a_reg;
        div_b_next   = div_b_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        az_next      = az_reg;
        rad_next     = rad_reg;
        sq_cnt_next  = sq_cnt_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        sqz_next     = sqz_reg;
        radsq_next   = radsq_reg;
        r2s_next     = r2s_reg;
        nms_next     = nms_reg;
        neg_next     = neg_reg;
        ratio_next   = ratio_reg;
        sv_next      = sv_reg;
        sr_next      = sr_reg;
        sbit_next    = sbit_reg;
        rr_next      = rr_reg;
        btmp_next    = btmp_reg;
        b_next       = b_reg;
        inv3_next    = inv3_reg;
        inv_sat_next = inv_sat_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;

        case (state_reg)
            T_IDLE:
            begin
                if (go)
                begin
                    ax_next      = mx[32:4];
                    ay_next      = my[32:4];
                    az_next      = mz[32:4];
                    rad_next     = src.radius[30:4];
                    sq_cnt_next  = 2'd0;
                    inv_sat_next = 1'b0;
                    state_next   = T_SQ;
                end
            end
            T_SQ:
            begin
                case (sq_cnt_reg)
                    2'd0:    sqx_next   = sq_prod;
                    2'd1:    sqy_next   = sq_prod;
                    2'd2:    sqz_next   = sq_prod;
                    default: radsq_next = sq_prod;
                endcase
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd3)
                begin
                    state_next = T_SUM;
                end
            end
            T_SUM:
            begin
                // inside the exclusion radius (or coincident): no term
                if (r2_sum <= radsq_reg)
                begin
                    res_next.done  = 1'b1;
                    res_next.sat   = 1'b0;
                    res_next.value = 64'sd0;
                    state_next     = T_IDLE;
                end
                else
                begin
                    r2s_next   = r2_sum;
                    nms_next   = nmag[58:0];
                    neg_next   = num[59];
                    sv_next    = r2_sum;
                    sr_next    = 58'd0;
                    sbit_next  = 58'd1 << 56;
                    state_next = T_NORM;
                end
            end
            T_NORM:
            begin
                // bring r^2 below 2^32 for the ratio division
                if (|r2s_reg[57:32])
                begin
                    r2s_next = r2s_reg >> 1;
                    nms_next = nms_reg >> 1;
                end
                else
                begin
                    div_go_next = 1'b1;
                    div_a_next  = {nms_reg[33:0], 30'd0};
                    div_b_next  = r2s_reg[31:0];
                    state_next  = T_RATIO;
                end
            end
            T_RATIO:
            begin
                if (div_done)
                begin
                    ratio_next = div_q[31:0];
                    state_next = T_SQRT;
                end
            end
            T_SQRT:
            begin
                sv_next   = sv_step;
                sr_next   = sr_step;
                sbit_next = sbit_reg >> 2;
                if (sbit_reg[0])
                begin
                    rr_next    = sr_step[28:0];
                    btmp_next  = sr_step[28:0];
                    b_next     = 5'd0;
                    state_next = T_BLEN;
                end
            end
            T_BLEN:
            begin
                // bit length of the root
                if (btmp_reg == 29'd0)
                begin
                    div_go_next = 1'b1;
                    div_a_next  = I64MIN;
                    div_b_next  = {3'b000, rr_reg};
                    state_next  = T_DIV1;
                end
                else
                begin
                    btmp_next = btmp_reg >> 1;
                    b_next    = b_reg + 5'd1;
                end
            end
            T_DIV1:
            begin
                if (div_done)
                begin
                    div_go_next = 1'b1;
                    div_a_next  = dshift;
                    div_b_next  = {3'b000, rr_reg};
                    state_next  = T_DIV2;
                end
            end
            T_DIV2:
            begin
                if (div_done)
                begin
                    div_go_next = 1'b1;
                    div_a_next  = dshift;
                    div_b_next  = {3'b000, rr_reg};
                    state_next  = T_DIV3;
                end
            end
            T_DIV3:
            begin
                if (div_done)
                begin
                    if (b_reg >= 5'd4)
                    begin
                        inv3_next = div_q >> s_dn;
                    end
                    else if (div_q > inv_lim)
                    begin
                        inv3_next    = I64MAX;
                        inv_sat_next = 1'b1;
                    end
                    else
                    begin
                        inv3_next = div_q << s_up;
                    end
                    state_next = T_MUL0;
                end
            end
            T_MUL0:
            begin
                p0_next    = mul_p;
                state_next = T_MUL1;
            end
            T_MUL1:
            begin
                p1_next    = mul_p;
                state_next = T_FIN;
            end
            T_FIN:
            begin
                res_next.done  = 1'b1;
                res_next.sat   = inv_sat_reg | mul_sat;
                res_next.value = neg_reg ? (~tm + 64'd1) : tm;
                state_next     = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            res_reg    <= '0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            res_reg    <= res_next;
            div_go_reg <= div_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_a_reg   <= div_a_next;
        div_b_reg   <= div_b_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        az_reg      <= az_next;
        rad_reg     <= rad_next;
        sq_cnt_reg  <= sq_cnt_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        sqz_reg     <= sqz_next;
        radsq_reg   <= radsq_next;
        r2s_reg     <= r2s_next;
        nms_reg     <= nms_next;
        neg_reg     <= neg_next;
        ratio_reg   <= ratio_next;
        sv_reg      <= sv_next;
        sr_reg      <= sr_next;
        sbit_reg    <= sbit_next;
        rr_reg      <= rr_next;
        btmp_reg    <= btmp_next;
        b_reg       <= b_next;
        inv3_reg    <= inv3_next;
        inv_sat_reg <= inv_sat_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
    end

    assign res = res_reg;

endmodule

// ----- design/dipole_field_voxel_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipole_field_voxel_sum: summed dipole field at a voxel position
// Source table as a rotating chain of cells feeding one term engine.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries clear, append and query requests. Clear and
//   append give no result. A query walks the source chain: the head cell
//   feeds the term engine, and the chain rotates once per source and then
//   on to a full turn before the sum is scaled; a source inside its
//   radius gives a zero term without the divisions or the square root. The
//   per-source cost is set by the serial divider (four 64-step divisions)
//   and the serial square root.
//   res (valid/ready) carries one result per query from an output register;
//   new requests are taken while a result waits. A finished query holds in
//   its last step until the output register is free.
//   cfg (valid/ready, always ready) writes the scale register.
//   Reset empties the table and clears the scale register.
// ----------------------------------------------------------------------------
module dipole_field_voxel_sum
    import dfvs_pkg::*;
#(
    parameter int MAX_SOURCES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_scale
);

    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SOURCES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOOK = 7'b0000010,
        S_TERM = 7'b0000100,
        S_ABS  = 7'b0001000,
        S_MUL0 = 7'b0010000,
        S_MUL1 = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  rot_reg, rot_next;
    logic [31:0]    scale_reg, scale_next;
    logic           res_valid_reg, res_valid_next;
    res_t           res_reg, res_next;
    req_t           qry_reg, qry_next;
    logic [63:0]    sum_reg, sum_next;
    logic           sat_reg, sat_next;
    logic [63:0]    smag_reg, smag_next;
    logic [31:0]    cmag_reg, cmag_next;
    logic           neg_reg, neg_next;
    logic [63:0]    m0_reg, m0_next, m1_reg, m1_next;

    logic           accept;
    logic           append_en;
    logic           rotate;
    logic           term_go;
    term_res_t      term_res;
    src_t           cell_src [MAX_SOURCES];
    src_t           new_src;

    logic [63:0]    s_add;
    logic           ovf;
    logic [95:0]    prod;
    logic [71:0]    shv;
    logic [47:0]    lim48, v48;
    logic           over;
    logic           out_free;

    assign accept    = req_valid && req_ready;
    assign append_en = accept && req.kind == KIND_APPEND;
    assign term_go   = state_reg == S_LOOK && rot_reg < count_reg;
    assign rotate    = (state_reg == S_LOOK && rot_reg >= count_reg && rot_reg != MAXC)
                       || (state_reg == S_TERM && term_res.done);
    assign out_free  = !res_valid_reg || res_ready;

    always_comb
    begin
        new_src.x      = req.pos_x;
        new_src.y      = req.pos_y;
        new_src.z      = req.pos_z;
        new_src.radius = req.radius;
    end

    // source chain, head at cell 0
    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % MAX_SOURCES;
        dfvs_cell u_cell (
            .clk      (clk),
            .load     (append_en && count_reg == CW'(i)),
            .shift    (rotate),
            .load_src (new_src),
            .next_src (cell_src[NXT]),
            .src      (cell_src[i])
        );
    end

    dfvs_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (term_go),
        .src   (cell_src[0]),
        .qry   (qry_reg),
        .res   (term_res)
    );

    // saturating accumulate and final scaling
    always_comb
    begin
        s_add = sum_reg + term_res.value;
        ovf   = (sum_reg[63] == term_res.value[63]) && (s_add[63] != sum_reg[63]);
        prod  = {32'd0, m0_reg} + {m1_reg, 32'd0};
        shv   = prod[95:24];
        lim48 = neg_reg ? NEG47 : POS47;
        over  = (|shv[71:48]) || (shv[47:0] > lim48);
        v48   = over ? lim48 : shv[47:0];
    end

    // control sequence
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rot_next       = rot_reg;
        scale_next     = cfg_valid ? cfg_scale : scale_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        qry_next       = qry_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        smag_next      = smag_reg;
        cmag_next      = cmag_reg;
        neg_next       = neg_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg != MAXC)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_QUERY:
                        begin
                            qry_next   = req;
                            sum_next   = 64'd0;
                            sat_next   = 1'b0;
                            rot_next   = '0;
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (rot_reg < count_reg)
                begin
                    state_next = S_TERM;
                end
                else if (rot_reg != MAXC)
                begin
                    rot_next = rot_reg + CW'(1);
                end
                else
                begin
                    state_next = S_ABS;
                end
            end
            S_TERM:
            begin
                if (term_res.done)
                begin
                    sat_next = sat_reg | term_res.sat | ovf;
                    sum_next = ovf ? (term_res.value[63] ? I64MIN : I64MAX) : s_add;
                    rot_next = rot_reg + CW'(1);
                    state_next = S_LOOK;
                end
            end
            S_ABS:
            begin
                smag_next  = sum_reg[63] ? (~sum_reg + 64'd1) : sum_reg;
                cmag_next  = scale_reg[31] ? (~scale_reg + 32'd1) : scale_reg;
                neg_next   = sum_reg[63] ^ scale_reg[31];
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                m0_next    = {32'd0, smag_reg[31:0]} * {32'd0, cmag_reg};
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                m1_next    = {32'd0, smag_reg[63:32]} * {32'd0, cmag_reg};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    res_next.field_value = neg_reg ? (~v48 + 48'd1) : v48;
                    res_next.saturated   = sat_reg | over;
                    res_next.table_full  = count_reg == MAXC;
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rot_reg       <= '0;
            scale_reg     <= 32'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rot_reg       <= rot_next;
            scale_reg     <= scale_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        qry_reg  <= qry_next;
        sum_reg  <= sum_next;
        sat_reg  <= sat_next;
        smag_reg <= smag_next;
        cmag_reg <= cmag_next;
        neg_reg  <= neg_next;
        m0_reg   <= m0_next;
        m1_reg   <= m1_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cfg_ready = 1'b1;

endmodule
